[rtl/pba_pkg.sv]
// Shared constants, codes and types for the packet buffer allocator.
package pba_pkg;

  // Index width of descriptors and buffers; index 0 means "none".
  localparam int IDX_W     = 8;
  localparam int MEM_DEPTH = 2 ** IDX_W;

  // Highest descriptor and buffer number on the free lists.
  localparam int PKT_COUNT = 255;
  localparam int BUF_COUNT = 255;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLONE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PKT   = 2'd1,
    ST_NO_BUF   = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_COUNT
  } state_t;

endpackage

[rtl/packet_buffer_allocator_refcount.sv]
// Descriptor and buffer free-list manager with buffer reference counts.
//
//  channel   handshake           payload
//  -------   ---------           -------
//  command   start / busy        op, pkt_index
//  result    done (one cycle)    new_pkt, buf_index, status, pkts_used, bufs_used
//
// Sequence: a command is taken when start is high and busy is low. Allocate,
//   op value 3 and every error word go from S_LOOK back to S_IDLE; free and
//   clone pass through S_COUNT too, since the buffer's reference count can only
//   be read once the descriptor-to-buffer map has returned the buffer number.
//   Each memory has one read and one write port with registered read data.
// Reset: rst (synchronous) starts a clearing pass over all 256 indices that
//   rebuilds both free lists and zeroes the map and the reference counts; busy
//   stays high during the pass.
// Stalls: the result word is shown for one cycle with done; the receiver
//   cannot hold it off. All memory writes of a command land before busy drops,
//   so the next command always reads fresh data.
module packet_buffer_allocator_refcount (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  op,
  input  logic [pba_pkg::IDX_W-1:0]   pkt_index,
  output logic                        busy,
  output logic                        done,
  output logic [pba_pkg::IDX_W-1:0]   new_pkt,
  output logic [pba_pkg::IDX_W-1:0]   buf_index,
  output logic [1:0]                  status,
  output logic [pba_pkg::IDX_W-1:0]   pkts_used,
  output logic [pba_pkg::IDX_W-1:0]   bufs_used
);

  localparam int W = pba_pkg::IDX_W;
  localparam logic [W-1:0] PKT_LAST = W'(pba_pkg::PKT_COUNT);
  localparam logic [W-1:0] BUF_LAST = W'(pba_pkg::BUF_COUNT);
  localparam logic [W-1:0] IDX_END  = W'(pba_pkg::MEM_DEPTH - 1);

  // Control registers
  pba_pkg::state_t state, state_next;
  logic [W-1:0]    clr_idx;
  pba_pkg::op_t    op_q;
  logic [W-1:0]    pidx_q;
  logic [W-1:0]    pkt_head, pkt_head_next;
  logic [W-1:0]    buf_head, buf_head_next;
  logic [W-1:0]    pkt_count, pkt_count_next;
  logic [W-1:0]    buf_count, buf_count_next;

  // Memories: free links, descriptor-to-buffer map, reference counts
  logic [W-1:0] pkt_link_mem [pba_pkg::MEM_DEPTH];
  logic [W-1:0] buf_link_mem [pba_pkg::MEM_DEPTH];
  logic [W-1:0] map_mem      [pba_pkg::MEM_DEPTH];
  logic [W-1:0] ref_mem      [pba_pkg::MEM_DEPTH];

  logic         pl_we, pl_re, bl_we, bl_re, map_we, map_re, ref_we, ref_re;
  logic [W-1:0] pl_wa, pl_wd, pl_rd;
  logic [W-1:0] bl_wa, bl_wd, bl_rd;
  logic [W-1:0] map_wa, map_wd, map_ra, map_rd;
  logic [W-1:0] ref_wa, ref_wd, ref_rd;
  logic [W-1:0] ref_dec;

  // Result staging
  logic                  res_load;
  logic [W-1:0]          res_np, res_bi;
  pba_pkg::status_t      res_st;

  logic accept, in_use, need_count;

  assign busy   = (state != pba_pkg::S_IDLE);
  assign accept = start && !busy;

  // A descriptor is in use when it is on the map with a nonzero buffer.
  assign in_use = (pidx_q != '0) && (pidx_q <= PKT_LAST) && (map_rd != '0);

  // Free and clone go on to read the reference count when no error shows.
  assign need_count = (op_q == pba_pkg::OP_FREE || op_q == pba_pkg::OP_CLONE) && in_use &&
                      !(op_q == pba_pkg::OP_CLONE && pkt_head == '0);

  assign ref_dec = (ref_rd == '0) ? '0 : ref_rd - 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pba_pkg::S_CLEAR: begin
        if (clr_idx == IDX_END) begin
          state_next = pba_pkg::S_IDLE;
        end
      end
      pba_pkg::S_IDLE: begin
        if (start) begin
          state_next = pba_pkg::S_LOOK;
        end
      end
      pba_pkg::S_LOOK: begin
        state_next = need_count ? pba_pkg::S_COUNT : pba_pkg::S_IDLE;
      end
      pba_pkg::S_COUNT: begin
        state_next = pba_pkg::S_IDLE;
      end
      default: begin
        state_next = pba_pkg::S_IDLE;
      end
    endcase
  end

  // Memory controls, list updates and result word
  always_comb begin
    pl_we = 1'b0;  pl_wa = '0;  pl_wd = '0;  pl_re = 1'b0;
    bl_we = 1'b0;  bl_wa = '0;  bl_wd = '0;  bl_re = 1'b0;
    map_we = 1'b0; map_wa = '0; map_wd = '0; map_re = 1'b0; map_ra = pkt_index;
    ref_we = 1'b0; ref_wa = '0; ref_wd = '0; ref_re = 1'b0;
    pkt_head_next  = pkt_head;
    buf_head_next  = buf_head;
    pkt_count_next = pkt_count;
    buf_count_next = buf_count;
    res_load = 1'b0;
    res_np   = '0;
    res_bi   = '0;
    res_st   = pba_pkg::ST_OK;

    case (state)
      pba_pkg::S_CLEAR: begin
        // Rebuild both free lists in index order, zero map and counts.
        pl_we  = 1'b1; pl_wa  = clr_idx;
        pl_wd  = (clr_idx == PKT_LAST) ? '0 : clr_idx + 1'b1;
        bl_we  = 1'b1; bl_wa  = clr_idx;
        bl_wd  = (clr_idx == BUF_LAST) ? '0 : clr_idx + 1'b1;
        map_we = 1'b1; map_wa = clr_idx;
        ref_we = 1'b1; ref_wa = clr_idx;
      end

      pba_pkg::S_IDLE: begin
        // Fetch the link under each head and the map entry of the operand.
        pl_re  = accept;
        bl_re  = accept;
        map_re = accept;
      end

      pba_pkg::S_LOOK: begin
        case (op_q)
          pba_pkg::OP_ALLOC: begin
            res_load = 1'b1;
            if (pkt_head == '0) begin
              res_st = pba_pkg::ST_NO_PKT;
            end else if (buf_head == '0) begin
              res_st = pba_pkg::ST_NO_BUF;
            end else begin
              // Pop both lists, link descriptor to buffer, count of one.
              pl_we  = 1'b1; pl_wa  = pkt_head; pl_wd  = '0;
              bl_we  = 1'b1; bl_wa  = buf_head; bl_wd  = '0;
              map_we = 1'b1; map_wa = pkt_head; map_wd = buf_head;
              ref_we = 1'b1; ref_wa = buf_head; ref_wd = W'(1);
              pkt_head_next  = pl_rd;
              buf_head_next  = bl_rd;
              pkt_count_next = pkt_count + 1'b1;
              buf_count_next = buf_count + 1'b1;
              res_np = pkt_head;
              res_bi = buf_head;
            end
          end
          pba_pkg::OP_FREE, pba_pkg::OP_CLONE: begin
            if (!in_use) begin
              res_load = 1'b1;
              res_st   = pba_pkg::ST_NOT_USED;
            end else if (op_q == pba_pkg::OP_CLONE && pkt_head == '0) begin
              res_load = 1'b1;
              res_st   = pba_pkg::ST_NO_PKT;
            end else begin
              ref_re = 1'b1;
            end
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end

      pba_pkg::S_COUNT: begin
        res_load = 1'b1;
        res_bi   = map_rd;
        if (op_q == pba_pkg::OP_FREE) begin
          // Unlink the descriptor and push it; push the buffer at count zero.
          map_we = 1'b1; map_wa = pidx_q; map_wd = '0;
          pl_we  = 1'b1; pl_wa  = pidx_q; pl_wd  = pkt_head;
          ref_we = 1'b1; ref_wa = map_rd; ref_wd = ref_dec;
          pkt_head_next  = pidx_q;
          pkt_count_next = pkt_count - 1'b1;
          if (ref_dec == '0) begin
            bl_we = 1'b1; bl_wa = map_rd; bl_wd = buf_head;
            buf_head_next  = map_rd;
            buf_count_next = buf_count - 1'b1;
          end
        end else begin
          // Clone: pop a descriptor onto the shared buffer, raise its count.
          pl_we  = 1'b1; pl_wa  = pkt_head; pl_wd  = '0;
          map_we = 1'b1; map_wa = pkt_head; map_wd = map_rd;
          ref_we = 1'b1; ref_wa = map_rd;   ref_wd = ref_rd + 1'b1;
          pkt_head_next  = pl_rd;
          pkt_count_next = pkt_count + 1'b1;
          res_np = pkt_head;
        end
      end

      default: begin
      end
    endcase
  end

  // Memories with registered read data
  always_ff @(posedge clk) begin
    if (pl_we) begin
      pkt_link_mem[pl_wa] <= pl_wd;
    end
    if (pl_re) begin
      pl_rd <= pkt_link_mem[pkt_head];
    end
  end

  always_ff @(posedge clk) begin
    if (bl_we) begin
      buf_link_mem[bl_wa] <= bl_wd;
    end
    if (bl_re) begin
      bl_rd <= buf_link_mem[buf_head];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_rd <= map_mem[map_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    if (ref_re) begin
      ref_rd <= ref_mem[map_rd];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pba_pkg::S_CLEAR;
      clr_idx   <= '0;
      pkt_head  <= W'(1);
      buf_head  <= W'(1);
      pkt_count <= '0;
      buf_count <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      pkt_head  <= pkt_head_next;
      buf_head  <= buf_head_next;
      pkt_count <= pkt_count_next;
      buf_count <= buf_count_next;
      done      <= res_load;
      if (state == pba_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Command capture and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= pba_pkg::op_t'(op);
      pidx_q <= pkt_index;
    end
    if (res_load) begin
      new_pkt   <= res_np;
      buf_index <= res_bi;
      status    <= res_st;
      pkts_used <= pkt_count_next;
      bufs_used <= buf_count_next;
    end
  end

  // Assertions
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy did not rise after a command was taken");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a command in flight");

  a_empty_list_full: assert property (@(posedge clk) disable iff (rst)
    (pkt_head == '0) |-> (pkt_count == PKT_LAST))
    else $error("descriptor list empty while descriptors remain free");

  a_new_pkt_has_buf: assert property (@(posedge clk) disable iff (rst)
    (done && status == pba_pkg::ST_OK && new_pkt != '0) |-> (buf_index != '0))
    else $error("descriptor given out without a buffer");

endmodule
